/* hw/rtl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, widths and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    // default fraction bits of the Q format
    localparam int FRAC_BITS = 8;

    // fixed widths
    localparam int WORD_W = 16;
    localparam int PROD_W = 2 * WORD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SAT_W  = SUM_W + 1;
    localparam int DEN_W  = PROD_W;
    localparam int QUOT_W = WORD_W + 1;

    localparam logic signed [SAT_W-1:0] SAT_HI = 32767;
    localparam logic signed [SAT_W-1:0] SAT_LO = -32768;
    localparam logic [QUOT_W:0] NEG_LIMIT = 18'd32768;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // saturated word plus clip flag
    typedef struct packed {
        logic              sat;
        logic [WORD_W-1:0] val;
    } sat_t;

    // control and early result travelling with each transaction
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              dz;
        logic              sat;
        logic [WORD_W-1:0] re;
        logic [WORD_W-1:0] im;
    } ctl_t;

    // raw quotient of one divider lane
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic              rem_nz;
        logic [QUOT_W-1:0] q;
    } lane_res_t;

    // clip a wide signed value to one word
    function automatic sat_t sat_word(input logic signed [SAT_W-1:0] x);
        sat_t r;
        if (x > SAT_HI)
        begin
            r.sat = 1'b1;
            r.val = 16'h7fff;
        end
        else if (x < SAT_LO)
        begin
            r.sat = 1'b1;
            r.val = 16'h8000;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = x[WORD_W-1:0];
        end
        return r;
    endfunction

    // turn a magnitude quotient into a floored, clipped signed word
    function automatic sat_t div_word(input lane_res_t r);
        sat_t               s;
        logic [QUOT_W:0]    qc;
        qc = {1'b0, r.q} + (QUOT_W + 1)'(r.rem_nz);
        if (!r.neg)
        begin
            // positive quotient clips above 32767
            s.sat = r.ovf | (r.q[QUOT_W-1:WORD_W-1] != '0);
            s.val = s.sat ? 16'h7fff : r.q[WORD_W-1:0];
        end
        else
        begin
            s.sat = r.ovf | (qc > NEG_LIMIT);
            s.val = s.sat ? 16'h8000 : WORD_W'((QUOT_W + 1)'(0) - qc);
        end
        return s;
    endfunction

endpackage

/* hw/rtl/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// ----------------------------------------------------------------------------
// Takes one transaction every clock cycle; busy is always low. Each result
// passes through three front stages, a magnitude stage, one stage per bit
// of the 17-bit divider quotient and one output stage, for every operation
// alike, and is shown with done for exactly one cycle. The
// receiver cannot stall the unit, so results must be taken when done is high.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          op,
    input  logic signed [cau_pkg::WORD_W-1:0]   a_real,
    input  logic signed [cau_pkg::WORD_W-1:0]   a_imag,
    input  logic signed [cau_pkg::WORD_W-1:0]   b_real,
    input  logic signed [cau_pkg::WORD_W-1:0]   b_imag,
    output logic                                done,
    output logic signed [cau_pkg::WORD_W-1:0]   out_real,
    output logic signed [cau_pkg::WORD_W-1:0]   out_imag,
    output logic                                saturated,
    output logic                                divide_by_zero
);

    cau_pkg::ctl_t                      front_ctl, div_ctl;
    logic signed [cau_pkg::SUM_W-1:0]   num_re, num_im;
    logic [cau_pkg::DEN_W-1:0]          den;
    cau_pkg::lane_res_t                 res_re, res_im;
    cau_pkg::sat_t                      fin_re, fin_im;

    logic                               done_reg;
    logic [cau_pkg::WORD_W-1:0]         re_reg, re_next;
    logic [cau_pkg::WORD_W-1:0]         im_reg, im_next;
    logic                               sat_reg, sat_next;
    logic                               dz_reg, dz_next;

    assign busy = 1'b0;

    // products and sums
    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .op       (op),
        .a_real   (a_real),
        .a_imag   (a_imag),
        .b_real   (b_real),
        .b_imag   (b_imag),
        .ctl      (front_ctl),
        .num_re   (num_re),
        .num_im   (num_im),
        .den      (den)
    );

    // quotient pipeline
    cau_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (front_ctl),
        .num_re  (num_re),
        .num_im  (num_im),
        .den     (den),
        .ctl_out (div_ctl),
        .res_re  (res_re),
        .res_im  (res_im)
    );

    // result select: early result, divide by zero or divider quotient
    always_comb
    begin
        fin_re = cau_pkg::div_word(res_re);
        fin_im = cau_pkg::div_word(res_im);
        if (!div_ctl.is_div)
        begin
            re_next  = div_ctl.re;
            im_next  = div_ctl.im;
            sat_next = div_ctl.sat;
            dz_next  = 1'b0;
        end
        else if (div_ctl.dz)
        begin
            re_next  = '0;
            im_next  = '0;
            sat_next = 1'b0;
            dz_next  = 1'b1;
        end
        else
        begin
            re_next  = fin_re.val;
            im_next  = fin_im.val;
            sat_next = fin_re.sat | fin_im.sat;
            dz_next  = 1'b0;
        end
    end

    // output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_ctl.valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        re_reg  <= re_next;
        im_reg  <= im_next;
        sat_reg <= sat_next;
        dz_reg  <= dz_next;
    end

    assign done           = done_reg;
    assign out_real       = re_reg;
    assign out_imag       = im_reg;
    assign saturated      = sat_reg;
    assign divide_by_zero = dz_reg;

    // divide by zero gives a clean zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> (out_real == '0 && out_imag == '0 && !saturated))
        else $error("divide by zero result not zero");

    // a clipped result sits at a limit in at least one part
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (out_real == 16'h7fff || out_real == 16'h8000 ||
                                 out_imag == 16'h7fff || out_imag == 16'h8000))
        else $error("saturated flag without a clipped part");

    // strobe follows the pipeline valid in the next cycle
    a_done_track: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.valid |=> done)
        else $error("result strobe lost");

endmodule

/* hw/rtl/cau_front.sv */
// ----------------------------------------------------------------------------
// cau_front
// Operand register, product stage and sum stage. Finishes add, subtract and
// multiply; hands numerators and denominator of a divide to the divider.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic [1:0]                              op,
    input  logic signed [cau_pkg::WORD_W-1:0]       a_real,
    input  logic signed [cau_pkg::WORD_W-1:0]       a_imag,
    input  logic signed [cau_pkg::WORD_W-1:0]       b_real,
    input  logic signed [cau_pkg::WORD_W-1:0]       b_imag,
    output cau_pkg::ctl_t                           ctl,
    output logic signed [cau_pkg::SUM_W-1:0]        num_re,
    output logic signed [cau_pkg::SUM_W-1:0]        num_im,
    output logic [cau_pkg::DEN_W-1:0]               den
);

    // stage 1: operand registers
    logic                                  v1_reg;
    cau_pkg::op_t                          op1_reg;
    logic signed [cau_pkg::WORD_W-1:0]     ar1_reg, ai1_reg, br1_reg, bi1_reg;

    // stage 2: products
    logic                                  v2_reg;
    cau_pkg::op_t                          op2_reg;
    logic signed [cau_pkg::PROD_W-1:0]     prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [cau_pkg::PROD_W-1:0]     pbr_reg, pbi_reg;
    logic signed [cau_pkg::WORD_W:0]       sre_reg, sim_reg;
    logic                                  bz2_reg;

    // stage 3: sums
    cau_pkg::ctl_t                         ctl_reg, ctl_next;
    logic signed [cau_pkg::SUM_W-1:0]      nre_reg, nim_reg;
    logic [cau_pkg::DEN_W-1:0]             den_reg;

    logic signed [cau_pkg::SUM_W-1:0]      mul_re, mul_im;
    logic signed [cau_pkg::SUM_W-1:0]      mul_re_sh, mul_im_sh;
    cau_pkg::sat_t                         pre_re, pre_im;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        op1_reg <= cau_pkg::op_t'(op);
        ar1_reg <= a_real;
        ai1_reg <= a_imag;
        br1_reg <= b_real;
        bi1_reg <= b_imag;
    end

    // products and add/subtract
    always_ff @(posedge clk)
    begin
        op2_reg <= op1_reg;
        prr_reg <= ar1_reg * br1_reg;
        pii_reg <= ai1_reg * bi1_reg;
        pri_reg <= ar1_reg * bi1_reg;
        pir_reg <= ai1_reg * br1_reg;
        pbr_reg <= br1_reg * br1_reg;
        pbi_reg <= bi1_reg * bi1_reg;
        bz2_reg <= (br1_reg == '0) && (bi1_reg == '0);
        if (op1_reg == cau_pkg::OP_SUB)
        begin
            sre_reg <= (cau_pkg::WORD_W + 1)'(ar1_reg) - (cau_pkg::WORD_W + 1)'(br1_reg);
            sim_reg <= (cau_pkg::WORD_W + 1)'(ai1_reg) - (cau_pkg::WORD_W + 1)'(bi1_reg);
        end
        else
        begin
            sre_reg <= (cau_pkg::WORD_W + 1)'(ar1_reg) + (cau_pkg::WORD_W + 1)'(br1_reg);
            sim_reg <= (cau_pkg::WORD_W + 1)'(ai1_reg) + (cau_pkg::WORD_W + 1)'(bi1_reg);
        end
    end

    // multiply result, floored by the fraction shift
    assign mul_re    = cau_pkg::SUM_W'(prr_reg) - cau_pkg::SUM_W'(pii_reg);
    assign mul_im    = cau_pkg::SUM_W'(pri_reg) + cau_pkg::SUM_W'(pir_reg);
    assign mul_re_sh = mul_re >>> FRAC_BITS;
    assign mul_im_sh = mul_im >>> FRAC_BITS;

    // early result for the non-divide operations
    always_comb
    begin
        pre_re = '0;
        pre_im = '0;
        case (op2_reg)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB:
            begin
                pre_re = cau_pkg::sat_word(cau_pkg::SAT_W'(sre_reg));
                pre_im = cau_pkg::sat_word(cau_pkg::SAT_W'(sim_reg));
            end
            cau_pkg::OP_MUL:
            begin
                pre_re = cau_pkg::sat_word(cau_pkg::SAT_W'(mul_re_sh));
                pre_im = cau_pkg::sat_word(cau_pkg::SAT_W'(mul_im_sh));
            end
            default:
            begin
                pre_re = '0;
                pre_im = '0;
            end
        endcase
        ctl_next.valid  = v2_reg;
        ctl_next.is_div = (op2_reg == cau_pkg::OP_DIV);
        ctl_next.dz     = bz2_reg;
        ctl_next.sat    = pre_re.sat | pre_im.sat;
        ctl_next.re     = pre_re.val;
        ctl_next.im     = pre_im.val;
    end

    // stage 3 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_next;
    end

    // divide numerators and denominator
    always_ff @(posedge clk)
    begin
        nre_reg <= cau_pkg::SUM_W'(prr_reg) + cau_pkg::SUM_W'(pii_reg);
        nim_reg <= cau_pkg::SUM_W'(pir_reg) - cau_pkg::SUM_W'(pri_reg);
        den_reg <= cau_pkg::DEN_W'(pbr_reg) + cau_pkg::DEN_W'(pbi_reg);
    end

    assign ctl    = ctl_reg;
    assign num_re = nre_reg;
    assign num_im = nim_reg;
    assign den    = den_reg;

endmodule

/* hw/rtl/cau_div_pipe.sv */
// ----------------------------------------------------------------------------
// cau_div_pipe
// Two-lane pipelined restoring divider: magnitude and overflow stage, then
// one quotient bit per stage for the real and imaginary numerators.
// ----------------------------------------------------------------------------
module cau_div_pipe #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cau_pkg::ctl_t                       ctl_in,
    input  logic signed [cau_pkg::SUM_W-1:0]    num_re,
    input  logic signed [cau_pkg::SUM_W-1:0]    num_im,
    input  logic [cau_pkg::DEN_W-1:0]           den,
    output cau_pkg::ctl_t                       ctl_out,
    output cau_pkg::lane_res_t                  res_re,
    output cau_pkg::lane_res_t                  res_im
);

    localparam int QB = cau_pkg::QUOT_W;
    localparam int MW = cau_pkg::SUM_W + FRAC_BITS;
    localparam int CW = cau_pkg::DEN_W + QB;

    // stage registers, index 0 is the magnitude stage
    cau_pkg::ctl_t              ctl_q [0:QB];
    logic [cau_pkg::DEN_W-1:0]  d_q   [0:QB];
    logic [MW-1:0]              rem_q [0:1][0:QB];
    logic [QB-1:0]              quo_q [0:1][0:QB];
    logic                       neg_q [0:1][0:QB];
    logic                       ovf_q [0:1][0:QB];

    logic signed [cau_pkg::SUM_W-1:0] num_in [0:1];

    assign num_in[0] = num_re;
    assign num_in[1] = num_im;

    // control and divisor through the magnitude stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_q[0] <= '0;
        else
            ctl_q[0] <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        d_q[0] <= den;
    end

    genvar g_lane, g_stage;

    // magnitude, sign and quotient overflow per lane
    generate
        for (g_lane = 0; g_lane < 2; g_lane++)
        begin : g_mag
            logic [cau_pkg::SUM_W-1:0] mag;
            logic [MW-1:0]             mag_sh;

            assign mag    = num_in[g_lane][cau_pkg::SUM_W-1] ? cau_pkg::SUM_W'(-num_in[g_lane])
                                                             : num_in[g_lane];
            assign mag_sh = MW'(mag) << FRAC_BITS;

            always_ff @(posedge clk)
            begin
                rem_q[g_lane][0] <= mag_sh;
                quo_q[g_lane][0] <= '0;
                neg_q[g_lane][0] <= num_in[g_lane][cau_pkg::SUM_W-1];
                ovf_q[g_lane][0] <= CW'(mag_sh) >= (CW'(den) << QB);
            end
        end
    endgenerate

    // one quotient bit per stage
    generate
        for (g_stage = 0; g_stage < QB; g_stage++)
        begin : g_step
            localparam int BIT = QB - 1 - g_stage;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    ctl_q[g_stage+1] <= '0;
                else
                    ctl_q[g_stage+1] <= ctl_q[g_stage];
            end

            always_ff @(posedge clk)
            begin
                d_q[g_stage+1] <= d_q[g_stage];
            end

            for (g_lane = 0; g_lane < 2; g_lane++)
            begin : g_lane_step
                logic [CW-1:0] dsh;
                logic [CW-1:0] diff;
                logic          ge;

                assign dsh  = CW'(d_q[g_stage]) << BIT;
                assign ge   = CW'(rem_q[g_lane][g_stage]) >= dsh;
                assign diff = CW'(rem_q[g_lane][g_stage]) - dsh;

                always_ff @(posedge clk)
                begin
                    rem_q[g_lane][g_stage+1] <= ge ? diff[MW-1:0] : rem_q[g_lane][g_stage];
                    quo_q[g_lane][g_stage+1] <= quo_q[g_lane][g_stage] |
                                                (QB'(ge) << BIT);
                    neg_q[g_lane][g_stage+1] <= neg_q[g_lane][g_stage];
                    ovf_q[g_lane][g_stage+1] <= ovf_q[g_lane][g_stage];
                end
            end
        end
    endgenerate

    assign ctl_out       = ctl_q[QB];
    assign res_re.neg    = neg_q[0][QB];
    assign res_re.ovf    = ovf_q[0][QB];
    assign res_re.rem_nz = (rem_q[0][QB] != '0);
    assign res_re.q      = quo_q[0][QB];
    assign res_im.neg    = neg_q[1][QB];
    assign res_im.ovf    = ovf_q[1][QB];
    assign res_im.rem_nz = (rem_q[1][QB] != '0);
    assign res_im.q      = quo_q[1][QB];

endmodule
